@@ hw/rtl/gbt_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbt_pkg
// Shared constants, codes and controller/datapath types of the graph
// traversal block.
// ----------------------------------------------------------------------------
package gbt_pkg;

  localparam int unsigned VTX_W            = 6;
  localparam int unsigned DEF_MAX_VERTICES = 64;
  localparam int unsigned DEF_MAX_ARCS     = 256;
  localparam int unsigned RESULT_CAP       = 64;
  localparam int unsigned RES_W            = 7;

  typedef enum logic [1:0] {
    OP_ADD  = 2'd0,
    OP_BFS  = 2'd1,
    OP_DFS  = 2'd2,
    OP_NONE = 2'd3
  } op_e;

  typedef enum logic [4:0] {
    CMD_NONE,
    CMD_CLR_HEAD,
    CMD_ACCEPT,
    CMD_ARC_RD,
    CMD_ARC_WR,
    CMD_ARC_LINK,
    CMD_ADD_OK,
    CMD_ADD_BAD,
    CMD_ONE,
    CMD_CLR_VIS,
    CMD_B_INIT,
    CMD_B_POP,
    CMD_B_HEAD,
    CMD_B_EMIT,
    CMD_SCAN,
    CMD_TGT,
    CMD_B_VIS,
    CMD_D_INIT,
    CMD_D_INIT2,
    CMD_D_TOP,
    CMD_D_CUR,
    CMD_D_PUSHF,
    CMD_D_POP,
    CMD_D_PUSH,
    CMD_FLUSH
  } dp_cmd_e;

  typedef struct packed {
    op_e  op;
    logic start_ok;
    logic add_bad;
    logic arc_more;
    logic clr_last;
    logic can_emit;
    logic out_free;
    logic queue_ok;
    logic scan_end;
    logic take;
    logic stack_ok;
    logic sp_room;
  } dp_status_t;

endpackage

@@ hw/rtl/gbt_in_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbt_in_if
// Request channel: edge insertions and traversal starts.
// ----------------------------------------------------------------------------
interface gbt_in_if
  import gbt_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [1:0]       op;
  logic [VTX_W-1:0] from_vertex;
  logic [VTX_W-1:0] to_vertex;
  logic             directed;
  logic [VTX_W-1:0] start_vertex;

  modport source (output valid, op, from_vertex, to_vertex, directed, start_vertex,
                  input ready);
  modport sink   (input valid, op, from_vertex, to_vertex, directed, start_vertex,
                  output ready);
endinterface

@@ hw/rtl/gbt_out_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbt_out_if
// Result channel: visited vertices and edge status.
// ----------------------------------------------------------------------------
interface gbt_out_if
  import gbt_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [VTX_W-1:0] visited_vertex;
  logic             status;
  logic             last;

  modport source (output valid, visited_vertex, status, last, input ready);
  modport sink   (input valid, visited_vertex, status, last, output ready);
endinterface

@@ hw/rtl/graph_bfs_dfs_traversal.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// graph_bfs_dfs_traversal
// Adjacency-list graph store with breadth-first and depth-first traversal.
// ----------------------------------------------------------------------------
// One item at a time. After reset the head table is swept once before the
// first item is taken. An edge insertion reads, writes and links each stored
// arc in turn, then gives one status result. A traversal first clears the
// visited marks, then reaches vertices breadth-first or depth-first and scans
// their arcs one at a time, paced by the single read port of the arc pool and
// the visited RAM; results stream out as they are found, the final one
// flagged with last, at most 64 per item.
module graph_bfs_dfs_traversal
  import gbt_pkg::*;
#(
  parameter int unsigned MAX_VERTICES = DEF_MAX_VERTICES,
  parameter int unsigned MAX_ARCS     = DEF_MAX_ARCS
) (
  input logic       clk_i,
  input logic       rst_ni,
  gbt_in_if.sink    req_i,
  gbt_out_if.source rsp_o
);
  dp_cmd_e    cmd;
  dp_status_t sts;

  gbt_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(req_i.valid), .in_ready_o(req_i.ready),
    .sts_i(sts), .cmd_o(cmd)
  );

  gbt_dpath #(.MAX_VERTICES(MAX_VERTICES), .MAX_ARCS(MAX_ARCS)) u_dpath (
    .clk_i, .rst_ni,
    .cmd_i(cmd), .sts_o(sts),
    .op_i(req_i.op), .from_vertex_i(req_i.from_vertex), .to_vertex_i(req_i.to_vertex),
    .directed_i(req_i.directed), .start_vertex_i(req_i.start_vertex),
    .out_valid_o(rsp_o.valid), .out_ready_i(rsp_o.ready),
    .visited_vertex_o(rsp_o.visited_vertex), .status_o(rsp_o.status),
    .last_o(rsp_o.last)
  );
endmodule

@@ hw/rtl/gbt_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbt_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module gbt_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read, held while idle
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;
endmodule

@@ hw/rtl/gbt_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbt_ctrl
// Sequencer: steps the datapath through insertion, BFS and DFS.
// ----------------------------------------------------------------------------
module gbt_ctrl
  import gbt_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  dp_status_t sts_i,
  output dp_cmd_e    cmd_o
);
  typedef enum logic [27:0] {
    S_INIT     = 28'h0000001,
    S_IDLE     = 28'h0000002,
    S_DISPATCH = 28'h0000004,
    S_ADD_CHK  = 28'h0000008,
    S_ARC_RD   = 28'h0000010,
    S_ARC_WR   = 28'h0000020,
    S_ARC_LINK = 28'h0000040,
    S_ADD_OK   = 28'h0000080,
    S_CLR_VIS  = 28'h0000100,
    S_B_INIT   = 28'h0000200,
    S_B_POP    = 28'h0000400,
    S_B_HEAD   = 28'h0000800,
    S_B_EMIT   = 28'h0001000,
    S_B_SCAN   = 28'h0002000,
    S_B_TGT    = 28'h0004000,
    S_B_VIS    = 28'h0008000,
    S_D_INIT   = 28'h0010000,
    S_D_INIT2  = 28'h0020000,
    S_D_TOP    = 28'h0040000,
    S_D_CUR    = 28'h0080000,
    S_D_SCAN   = 28'h0100000,
    S_D_TGT    = 28'h0200000,
    S_D_VIS    = 28'h0400000,
    S_D_FOUND  = 28'h0800000,
    S_D_POP    = 28'h1000000,
    S_D_PUSH   = 28'h2000000,
    S_FLUSH    = 28'h4000000,
    S_SPARE    = 28'h8000000
  } state_e;

  state_e state_q, state_d;

  assign in_ready_o = (state_q == S_IDLE);

  // next state and command
  always_comb begin
    state_d = state_q;
    cmd_o   = CMD_NONE;
    case (state_q)
      S_INIT: begin
        cmd_o = CMD_CLR_HEAD;
        if (sts_i.clr_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o   = CMD_ACCEPT;
          state_d = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        case (sts_i.op)
          OP_ADD:  state_d = S_ADD_CHK;
          OP_NONE: state_d = S_IDLE;
          default: begin
            if (sts_i.start_ok) begin
              state_d = S_CLR_VIS;
            end else begin
              cmd_o   = CMD_ONE;
              state_d = S_FLUSH;
            end
          end
        endcase
      end
      S_ADD_CHK: begin
        if (sts_i.add_bad) begin
          cmd_o   = CMD_ADD_BAD;
          state_d = S_FLUSH;
        end else begin
          state_d = S_ARC_RD;
        end
      end
      S_ARC_RD: begin
        cmd_o   = CMD_ARC_RD;
        state_d = S_ARC_WR;
      end
      S_ARC_WR: begin
        cmd_o   = CMD_ARC_WR;
        state_d = S_ARC_LINK;
      end
      S_ARC_LINK: begin
        cmd_o   = CMD_ARC_LINK;
        state_d = sts_i.arc_more ? S_ARC_RD : S_ADD_OK;
      end
      S_ADD_OK: begin
        cmd_o   = CMD_ADD_OK;
        state_d = S_FLUSH;
      end
      S_CLR_VIS: begin
        cmd_o = CMD_CLR_VIS;
        if (sts_i.clr_last) state_d = (sts_i.op == OP_BFS) ? S_B_INIT : S_D_INIT;
      end
      S_B_INIT: begin
        cmd_o   = CMD_B_INIT;
        state_d = S_B_POP;
      end
      S_B_POP: begin
        if (sts_i.queue_ok) begin
          cmd_o   = CMD_B_POP;
          state_d = S_B_HEAD;
        end else begin
          state_d = S_FLUSH;
        end
      end
      S_B_HEAD: begin
        cmd_o   = CMD_B_HEAD;
        state_d = S_B_EMIT;
      end
      S_B_EMIT: begin
        if (sts_i.can_emit) begin
          cmd_o   = CMD_B_EMIT;
          state_d = S_B_SCAN;
        end
      end
      S_B_SCAN: begin
        if (sts_i.scan_end) begin
          state_d = S_B_POP;
        end else begin
          cmd_o   = CMD_SCAN;
          state_d = S_B_TGT;
        end
      end
      S_B_TGT: begin
        cmd_o   = CMD_TGT;
        state_d = S_B_VIS;
      end
      S_B_VIS: begin
        cmd_o   = CMD_B_VIS;
        state_d = S_B_SCAN;
      end
      S_D_INIT: begin
        cmd_o   = CMD_D_INIT;
        state_d = S_D_INIT2;
      end
      S_D_INIT2: begin
        cmd_o   = CMD_D_INIT2;
        state_d = S_D_TOP;
      end
      S_D_TOP: begin
        if (sts_i.stack_ok) begin
          cmd_o   = CMD_D_TOP;
          state_d = S_D_CUR;
        end else begin
          state_d = S_FLUSH;
        end
      end
      S_D_CUR: begin
        cmd_o   = CMD_D_CUR;
        state_d = S_D_SCAN;
      end
      S_D_SCAN: begin
        if (sts_i.scan_end) begin
          state_d = S_D_POP;
        end else begin
          cmd_o   = CMD_SCAN;
          state_d = S_D_TGT;
        end
      end
      S_D_TGT: begin
        cmd_o   = CMD_TGT;
        state_d = S_D_VIS;
      end
      S_D_VIS: begin
        state_d = sts_i.take ? S_D_FOUND : S_D_SCAN;
      end
      S_D_FOUND: begin
        if (!sts_i.sp_room) begin
          cmd_o   = CMD_D_POP;
          state_d = S_D_TOP;
        end else if (sts_i.can_emit) begin
          cmd_o   = CMD_D_PUSHF;
          state_d = S_D_PUSH;
        end
      end
      S_D_POP: begin
        cmd_o   = CMD_D_POP;
        state_d = S_D_TOP;
      end
      S_D_PUSH: begin
        cmd_o   = CMD_D_PUSH;
        state_d = S_D_TOP;
      end
      S_FLUSH: begin
        if (sts_i.out_free) begin
          cmd_o   = CMD_FLUSH;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
    end else begin
      state_q <= state_d;
    end
  end
endmodule

@@ hw/rtl/gbt_dpath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbt_dpath
// Adjacency store, visited marks, work list and result registers.
// ----------------------------------------------------------------------------
module gbt_dpath
  import gbt_pkg::*;
#(
  parameter int unsigned MAX_VERTICES = DEF_MAX_VERTICES,
  parameter int unsigned MAX_ARCS     = DEF_MAX_ARCS
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  dp_cmd_e          cmd_i,
  output dp_status_t       sts_o,
  input  logic [1:0]       op_i,
  input  logic [VTX_W-1:0] from_vertex_i,
  input  logic [VTX_W-1:0] to_vertex_i,
  input  logic             directed_i,
  input  logic [VTX_W-1:0] start_vertex_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [VTX_W-1:0] visited_vertex_o,
  output logic             status_o,
  output logic             last_o
);
  localparam int unsigned VIW   = $clog2(MAX_VERTICES);
  localparam int unsigned PW    = $clog2(MAX_VERTICES + 1);
  localparam int unsigned AW    = $clog2(MAX_ARCS + 1);
  localparam int unsigned AIW   = $clog2(MAX_ARCS);
  localparam int unsigned EXT_W = (VIW > VTX_W) ? VIW : VTX_W;
  localparam logic [AW-1:0] ARC_NULL = AW'(MAX_ARCS);

  function automatic logic [VIW-1:0] vidx(input logic [VTX_W-1:0] v);
    logic [EXT_W-1:0] e;
    e = EXT_W'(v);
    return e[VIW-1:0];
  endfunction

  function automatic logic vok(input logic [VTX_W-1:0] v);
    return 32'(v) < 32'(MAX_VERTICES);
  endfunction

  op_e              op_q;
  logic [VTX_W-1:0] u_q, v_q, s_q, f_q, t_q;
  logic             dir_q, second_q, link_q;
  logic [AW-1:0]    cnt_q, a_q;
  logic [VIW-1:0]   clr_q;
  logic [PW-1:0]    rp_q, wp_q, sp_q, spm1;
  logic [RES_W-1:0] n_q;
  logic             pend_v_q, pend_st_q;
  logic [VTX_W-1:0] pend_vtx_q;
  logic             out_v_q, out_st_q, out_last_q;
  logic [VTX_W-1:0] out_vtx_q;

  // ram ports
  logic             hd_we, hd_re, tl_we, tl_re, tg_we, nx_we, ar_re;
  logic             vs_we, vs_re, vs_wd, qu_we, qu_re, cu_we, cu_re;
  logic [VIW-1:0]   hd_wa, hd_ra, tl_a, vs_wa, vs_ra, qu_wa, qu_ra, cu_wa, cu_ra;
  logic [AW-1:0]    hd_wd, hd_rd, tl_rd, nx_wd, nx_rd, cu_wd, cu_rd;
  logic [AIW-1:0]   nx_wa;
  logic [VTX_W-1:0] tg_rd, qu_wd, qu_rd;
  logic             vs_rd;

  logic [VTX_W-1:0] src, dst;
  logic [AW:0]      need_sum;
  logic             clr_last, out_free, can_emit, pend_load, push_out, is_flush;
  logic [VTX_W-1:0] pend_vtx_d;
  logic             pend_st_d;

  assign src      = second_q ? v_q : u_q;
  assign dst      = second_q ? u_q : v_q;
  assign need_sum = {1'b0, cnt_q} + (dir_q ? (AW+1)'(1) : (AW+1)'(2));
  assign clr_last = (clr_q == VIW'(MAX_VERTICES - 1));
  assign spm1     = sp_q - PW'(1);
  assign out_free = !out_v_q || out_ready_i;
  assign can_emit = !pend_v_q || out_free;
  assign is_flush = (cmd_i == CMD_FLUSH);

  // status to the sequencer
  always_comb begin
    sts_o.op       = op_q;
    sts_o.start_ok = vok(s_q);
    sts_o.add_bad  = !vok(u_q) || !vok(v_q) || (32'(need_sum) > 32'(MAX_ARCS));
    sts_o.arc_more = !dir_q && !second_q;
    sts_o.clr_last = clr_last;
    sts_o.can_emit = can_emit;
    sts_o.out_free = out_free;
    sts_o.queue_ok = (rp_q < wp_q) && (n_q < RES_W'(RESULT_CAP));
    sts_o.scan_end = (a_q >= ARC_NULL);
    sts_o.take     = vok(t_q) && !vs_rd;
    sts_o.stack_ok = (sp_q != '0) && (n_q < RES_W'(RESULT_CAP));
    sts_o.sp_room  = (sp_q < PW'(MAX_VERTICES));
  end

  // decode memory traffic per command
  always_comb begin
    hd_we = 1'b0; hd_wa = clr_q; hd_wd = ARC_NULL;
    hd_re = 1'b0; hd_ra = vidx(src);
    tl_we = 1'b0; tl_re = 1'b0; tl_a = vidx(src);
    tg_we = 1'b0; nx_we = 1'b0; nx_wa = cnt_q[AIW-1:0]; nx_wd = ARC_NULL;
    ar_re = 1'b0;
    vs_we = 1'b0; vs_wa = clr_q; vs_wd = 1'b0; vs_re = 1'b0; vs_ra = vidx(tg_rd);
    qu_we = 1'b0; qu_wa = wp_q[VIW-1:0]; qu_wd = t_q; qu_re = 1'b0; qu_ra = rp_q[VIW-1:0];
    cu_we = 1'b0; cu_wa = spm1[VIW-1:0]; cu_wd = a_q; cu_re = 1'b0; cu_ra = spm1[VIW-1:0];
    pend_load = 1'b0; pend_vtx_d = '0; pend_st_d = 1'b0;
    case (cmd_i)
      CMD_CLR_HEAD: hd_we = 1'b1;
      CMD_ARC_RD: begin
        hd_re = 1'b1;
        tl_re = 1'b1;
      end
      CMD_ARC_WR: begin
        tg_we = 1'b1;
        nx_we = 1'b1;
        tl_we = 1'b1;
        hd_wa = vidx(src);
        hd_wd = cnt_q;
        hd_we = (hd_rd == ARC_NULL);
      end
      CMD_ARC_LINK: begin
        nx_we = link_q;
        nx_wa = tl_rd[AIW-1:0];
        nx_wd = cnt_q;
      end
      CMD_ADD_OK: pend_load = 1'b1;
      CMD_ADD_BAD: begin
        pend_load = 1'b1;
        pend_st_d = 1'b1;
      end
      CMD_ONE: begin
        pend_load  = 1'b1;
        pend_vtx_d = s_q;
      end
      CMD_CLR_VIS: vs_we = 1'b1;
      CMD_B_INIT: begin
        vs_we = 1'b1; vs_wa = vidx(s_q); vs_wd = 1'b1;
        qu_we = 1'b1; qu_wa = '0; qu_wd = s_q;
      end
      CMD_B_POP: qu_re = 1'b1;
      CMD_B_HEAD: begin
        hd_re = 1'b1;
        hd_ra = vidx(qu_rd);
      end
      CMD_B_EMIT: begin
        pend_load  = 1'b1;
        pend_vtx_d = f_q;
      end
      CMD_SCAN: ar_re = 1'b1;
      CMD_TGT: vs_re = 1'b1;
      CMD_B_VIS: begin
        if (vok(t_q) && !vs_rd && (wp_q < PW'(MAX_VERTICES))) begin
          vs_we = 1'b1; vs_wa = vidx(t_q); vs_wd = 1'b1;
          qu_we = 1'b1;
        end
      end
      CMD_D_INIT: begin
        pend_load  = 1'b1;
        pend_vtx_d = s_q;
        vs_we = 1'b1; vs_wa = vidx(s_q); vs_wd = 1'b1;
        hd_re = 1'b1; hd_ra = vidx(s_q);
      end
      CMD_D_INIT2: begin
        cu_we = 1'b1; cu_wa = '0; cu_wd = hd_rd;
      end
      CMD_D_TOP: cu_re = 1'b1;
      CMD_D_PUSHF: begin
        cu_we      = 1'b1;
        pend_load  = 1'b1;
        pend_vtx_d = t_q;
        vs_we = 1'b1; vs_wa = vidx(t_q); vs_wd = 1'b1;
        hd_re = 1'b1; hd_ra = vidx(t_q);
      end
      CMD_D_POP: cu_we = 1'b1;
      CMD_D_PUSH: begin
        cu_we = 1'b1; cu_wa = sp_q[VIW-1:0]; cu_wd = hd_rd;
      end
      default: ;
    endcase
  end

  assign push_out = (pend_load && pend_v_q) || is_flush;

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= '0;
      clr_q    <= '0;
      rp_q     <= '0;
      wp_q     <= '0;
      sp_q     <= '0;
      n_q      <= '0;
      second_q <= 1'b0;
      link_q   <= 1'b0;
      pend_v_q <= 1'b0;
      out_v_q  <= 1'b0;
      op_q     <= OP_NONE;
    end else begin
      case (cmd_i)
        CMD_ACCEPT: begin
          op_q     <= op_e'(op_i);
          second_q <= 1'b0;
        end
        CMD_CLR_HEAD, CMD_CLR_VIS: clr_q <= clr_last ? '0 : clr_q + VIW'(1);
        CMD_ARC_WR:   link_q <= (hd_rd != ARC_NULL);
        CMD_ARC_LINK: begin
          cnt_q    <= cnt_q + AW'(1);
          second_q <= 1'b1;
        end
        CMD_B_INIT: begin
          rp_q <= '0;
          wp_q <= PW'(1);
          n_q  <= '0;
        end
        CMD_B_POP:  rp_q <= rp_q + PW'(1);
        CMD_B_EMIT: n_q <= n_q + RES_W'(1);
        CMD_B_VIS:  if (qu_we) wp_q <= wp_q + PW'(1);
        CMD_D_INIT: n_q <= RES_W'(1);
        CMD_D_INIT2: sp_q <= PW'(1);
        CMD_D_PUSHF: n_q <= n_q + RES_W'(1);
        CMD_D_POP:  sp_q <= spm1;
        CMD_D_PUSH: sp_q <= sp_q + PW'(1);
        default: ;
      endcase
      // hold one result back so the final one can carry last
      if (pend_load) pend_v_q <= 1'b1;
      else if (is_flush) pend_v_q <= 1'b0;
      if (push_out) out_v_q <= 1'b1;
      else if (out_ready_i) out_v_q <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    case (cmd_i)
      CMD_ACCEPT: begin
        u_q   <= from_vertex_i;
        v_q   <= to_vertex_i;
        dir_q <= directed_i;
        s_q   <= start_vertex_i;
      end
      CMD_B_HEAD: f_q <= qu_rd;
      CMD_B_EMIT: a_q <= hd_rd;
      CMD_TGT: begin
        t_q <= tg_rd;
        a_q <= nx_rd;
      end
      CMD_D_CUR: a_q <= cu_rd;
      default: ;
    endcase
    if (pend_load) begin
      pend_vtx_q <= pend_vtx_d;
      pend_st_q  <= pend_st_d;
    end
    if (push_out) begin
      out_vtx_q  <= pend_vtx_q;
      out_st_q   <= pend_st_q;
      out_last_q <= is_flush;
    end
  end

  assign out_valid_o      = out_v_q;
  assign visited_vertex_o = out_vtx_q;
  assign status_o         = out_st_q;
  assign last_o           = out_last_q;

  // list heads and tails
  gbt_ram #(.WIDTH(AW), .DEPTH(MAX_VERTICES)) u_head (
    .clk_i, .we_i(hd_we), .waddr_i(hd_wa), .wdata_i(hd_wd),
    .re_i(hd_re), .raddr_i(hd_ra), .rdata_o(hd_rd)
  );
  gbt_ram #(.WIDTH(AW), .DEPTH(MAX_VERTICES)) u_tail (
    .clk_i, .we_i(tl_we), .waddr_i(tl_a), .wdata_i(cnt_q),
    .re_i(tl_re), .raddr_i(tl_a), .rdata_o(tl_rd)
  );

  // arc pool
  gbt_ram #(.WIDTH(VTX_W), .DEPTH(MAX_ARCS)) u_target (
    .clk_i, .we_i(tg_we), .waddr_i(cnt_q[AIW-1:0]), .wdata_i(dst),
    .re_i(ar_re), .raddr_i(a_q[AIW-1:0]), .rdata_o(tg_rd)
  );
  gbt_ram #(.WIDTH(AW), .DEPTH(MAX_ARCS)) u_next (
    .clk_i, .we_i(nx_we), .waddr_i(nx_wa), .wdata_i(nx_wd),
    .re_i(ar_re), .raddr_i(a_q[AIW-1:0]), .rdata_o(nx_rd)
  );

  // visited marks
  gbt_ram #(.WIDTH(1), .DEPTH(MAX_VERTICES)) u_visited (
    .clk_i, .we_i(vs_we), .waddr_i(vs_wa), .wdata_i(vs_wd),
    .re_i(vs_re), .raddr_i(vs_ra), .rdata_o(vs_rd)
  );

  // BFS queue and DFS cursor stack
  gbt_ram #(.WIDTH(VTX_W), .DEPTH(MAX_VERTICES)) u_queue (
    .clk_i, .we_i(qu_we), .waddr_i(qu_wa), .wdata_i(qu_wd),
    .re_i(qu_re), .raddr_i(qu_ra), .rdata_o(qu_rd)
  );
  gbt_ram #(.WIDTH(AW), .DEPTH(MAX_VERTICES)) u_cursor (
    .clk_i, .we_i(cu_we), .waddr_i(cu_wa), .wdata_i(cu_wd),
    .re_i(cu_re), .raddr_i(cu_ra), .rdata_o(cu_rd)
  );
endmodule

@@ hw/rtl/gbt_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbt_checker
// Port-level checks of the graph traversal block.
// ----------------------------------------------------------------------------
module gbt_checker
  import gbt_pkg::*;
(
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid_i,
  input logic             in_ready_i,
  input logic             out_valid_i,
  input logic             out_ready_i,
  input logic [VTX_W-1:0] vertex_i,
  input logic             status_i,
  input logic             last_i
);
  // a dropped edge is a single, final result
  a_drop_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && status_i |-> last_i)
    else $error("drop status without last");

  // dropped-edge status results carry vertex zero
  a_drop_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && status_i |-> vertex_i == '0)
    else $error("drop status with nonzero vertex");

  // one item at a time: no new item right after one is taken
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("ready right after accept");

  // stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(vertex_i) && $stable(last_i))
    else $error("result changed while stalled");
endmodule

bind graph_bfs_dfs_traversal gbt_checker u_gbt_checker (
  .clk_i(clk_i), .rst_ni(rst_ni),
  .in_valid_i(req_i.valid), .in_ready_i(req_i.ready),
  .out_valid_i(rsp_o.valid), .out_ready_i(rsp_o.ready),
  .vertex_i(rsp_o.visited_vertex), .status_i(rsp_o.status), .last_i(rsp_o.last)
);

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives edge insertions and breadth/depth-first traversals into
// graph_bfs_dfs_traversal with random gaps on both channels. A local graph
// model predicts every visit sequence and edge status, and each result
// item is compared field by field in arrival order.
// ----------------------------------------------------------------------------
module testbench;
  import gbt_pkg::*;

  localparam int NV       = DEF_MAX_VERTICES;
  localparam int NA       = DEF_MAX_ARCS;
  localparam int NRANDOM  = 410;

  typedef struct packed {
    logic [VTX_W-1:0] vtx;
    logic             status;
    logic             last;
  } rsp_item_t;

  typedef struct {
    op_e              op;
    logic [VTX_W-1:0] from_v;
    logic [VTX_W-1:0] to_v;
    logic             dir;
    logic [VTX_W-1:0] start_v;
    bit               typed;
    rsp_item_t        want;
  } req_row_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  gbt_in_if  req ();
  gbt_out_if rsp ();

  graph_bfs_dfs_traversal dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .rsp_o  (rsp)
  );

  always #5 clk_i = ~clk_i;

  // Graph model state
  int        head_arc [NV];
  int        tail_arc [NV];
  int        arc_tgt  [NA];
  int        arc_nxt  [NA];
  int        arc_used;
  bit        seen     [NV];
  int        work_vtx [NV];
  int        work_cur [NV];
  rsp_item_t visit_q  [$];

  int  errors    = 0;
  int  n_checked = 0;
  int  n_adds    = 0;
  int  n_walks   = 0;
  int  n_full    = 0;
  bit  quiet     = 0;

  task automatic report_mismatch(string what, int got, int want);
    errors++;
    $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
  endtask

  function automatic void push_visit(int v, int st);
    rsp_item_t r;
    r.vtx = v[VTX_W-1:0];
    r.status = st[0];
    r.last = 1'b0;
    visit_q = {visit_q, r};
  endfunction

  function automatic void link_arc(int u, int v);
    arc_tgt[arc_used] = v;
    arc_nxt[arc_used] = NA;
    if (head_arc[u] == NA) head_arc[u] = arc_used;
    else arc_nxt[tail_arc[u]] = arc_used;
    tail_arc[u] = arc_used;
    arc_used++;
  endfunction

  // Append the visit sequence or status that one request item causes
  function automatic void predict_visits(op_e op, int u, int v, bit dir, int s);
    int need, rd, wr, n, a, f, t, sp, found;
    case (op)
      OP_ADD: begin
        need = dir ? 1 : 2;
        if (arc_used + need > NA) begin
          push_visit(0, 1);
          n_full++;
        end else begin
          link_arc(u, v);
          if (!dir) link_arc(v, u);
          push_visit(0, 0);
        end
        visit_q[visit_q.size()-1].last = 1'b1;
      end
      OP_BFS: begin
        foreach (seen[i]) seen[i] = 0;
        rd = 0; wr = 0; n = 0;
        work_vtx[wr++] = s;
        seen[s] = 1;
        while (rd < wr && n < RESULT_CAP) begin
          f = work_vtx[rd++];
          push_visit(f, 0);
          n++;
          for (a = head_arc[f]; a < NA; a = arc_nxt[a]) begin
            t = arc_tgt[a];
            if (!seen[t] && wr < NV) begin
              seen[t] = 1;
              work_vtx[wr++] = t;
            end
          end
        end
        visit_q[visit_q.size()-1].last = 1'b1;
      end
      OP_DFS: begin
        foreach (seen[i]) seen[i] = 0;
        n = 1;
        push_visit(s, 0);
        seen[s] = 1;
        work_vtx[0] = s;
        work_cur[0] = head_arc[s];
        sp = 1;
        while (sp > 0 && n < RESULT_CAP) begin
          a = work_cur[sp-1];
          found = NV;
          while (a < NA) begin
            t = arc_tgt[a];
            a = arc_nxt[a];
            if (!seen[t]) begin
              found = t;
              break;
            end
          end
          work_cur[sp-1] = a;
          if (found < NV && sp < NV) begin
            push_visit(found, 0);
            n++;
            seen[found] = 1;
            work_vtx[sp] = found;
            work_cur[sp] = head_arc[found];
            sp++;
          end else begin
            sp--;
          end
        end
        visit_q[visit_q.size()-1].last = 1'b1;
      end
      default: ;
    endcase
  endfunction

  // Present one item after a random gap, hold until accepted
  task automatic send_item(req_row_t row);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req.valid        <= 1'b1;
    req.op           <= row.op;
    req.from_vertex  <= row.from_v;
    req.to_vertex    <= row.to_v;
    req.directed     <= row.dir;
    req.start_vertex <= row.start_v;
    do @(posedge clk_i); while (!req.ready);
    if (row.op == OP_ADD) n_adds++;
    else if (row.op != OP_NONE) n_walks++;
    if (row.typed) begin
      predict_visits(row.op, row.from_v, row.to_v, row.dir, row.start_v);
      void'(visit_q.pop_back());
      visit_q = {visit_q, row.want};
    end else begin
      predict_visits(row.op, row.from_v, row.to_v, row.dir, row.start_v);
    end
  endtask

  function automatic int pick_vertex();
    return ($urandom_range(0, 9) < 8) ? $urandom_range(0, 15) : $urandom_range(0, NV - 1);
  endfunction

  function automatic req_row_t mk(op_e op, int u, int v, int d, int s, int ty, rsp_item_t w);
    req_row_t r;
    r.op = op; r.from_v = u[VTX_W-1:0]; r.to_v = v[VTX_W-1:0]; r.dir = d[0];
    r.start_v = s[VTX_W-1:0];
    r.typed = ty[0]; r.want = w;
    return r;
  endfunction

  // Stimulus
  initial begin
    req_row_t  table_rows [$];
    req_row_t  row;
    rsp_item_t none;
    rsp_item_t ack_ok;
    rsp_item_t top_only;
    int        pick;
    none = '0;
    ack_ok = '{vtx: '0, status: 1'b0, last: 1'b1};
    top_only = '{vtx: VTX_W'(NV - 1), status: 1'b0, last: 1'b1};
    req.valid <= 1'b0;
    req.op <= OP_ADD;
    req.from_vertex <= '0;
    req.to_vertex <= '0;
    req.directed <= 1'b0;
    req.start_vertex <= '0;
    foreach (head_arc[i]) begin
      head_arc[i] = NA;
      tail_arc[i] = NA;
    end
    arc_used = 0;

    // Empty graph visits, extremes, self loop, ignored op, small graph walks
    table_rows = {table_rows, mk(OP_BFS, 0, 0, 0, 0, 1, ack_ok)};
    table_rows = {table_rows, mk(OP_DFS, 0, 0, 0, NV - 1, 1, top_only)};
    table_rows = {table_rows, mk(OP_ADD, 0, NV - 1, 0, 0, 1, ack_ok)};
    table_rows = {table_rows, mk(OP_ADD, NV - 1, 0, 1, 0, 1, ack_ok)};
    table_rows = {table_rows, mk(OP_ADD, 5, 5, 0, 0, 1, ack_ok)};
    table_rows = {table_rows, mk(OP_NONE, NV - 1, NV - 1, 1, NV - 1, 0, none)};
    table_rows = {table_rows, mk(OP_ADD, 1, 2, 1, 0, 0, none)};
    table_rows = {table_rows, mk(OP_ADD, 0, 1, 0, 0, 0, none)};
    table_rows = {table_rows, mk(OP_ADD, 2, 3, 0, 0, 0, none)};
    table_rows = {table_rows, mk(OP_ADD, 1, 4, 1, 0, 0, none)};
    table_rows = {table_rows, mk(OP_ADD, 4, 62, 0, 0, 0, none)};
    table_rows = {table_rows, mk(OP_BFS, 0, 0, 0, 0, 0, none)};
    table_rows = {table_rows, mk(OP_DFS, 0, 0, 0, 0, 0, none)};
    table_rows = {table_rows, mk(OP_BFS, 0, 0, 0, 5, 0, none)};
    table_rows = {table_rows, mk(OP_DFS, 0, 0, 0, NV - 1, 0, none)};
    table_rows = {table_rows, mk(OP_BFS, 0, 0, 0, 42, 0, none)};
    table_rows = {table_rows, mk(OP_DFS, 0, 0, 0, 21, 0, none)};
    table_rows = {table_rows, mk(OP_BFS, 0, 0, 0, 2, 0, none)};

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (table_rows[i]) send_item(table_rows[i]);

    for (int k = 0; k < NRANDOM; k++) begin
      if (k % 60 == 30) quiet = ~quiet;
      // Let the result side drain completely once mid-run
      if (k == NRANDOM / 2) begin
        req.valid <= 1'b0;
        while (visit_q.size() != 0) @(posedge clk_i);
      end
      pick = $urandom_range(0, 99);
      row = mk(OP_ADD, pick_vertex(), pick_vertex(), $urandom_range(0, 1), pick_vertex(),
               0, none);
      if (pick >= 95) row.op = OP_NONE;
      else if (pick >= 72) row.op = OP_DFS;
      else if (pick >= 50) row.op = OP_BFS;
      send_item(row);
    end
    req.valid <= 1'b0;

    while (visit_q.size() != 0) @(posedge clk_i);
    repeat (400) @(posedge clk_i);
    $display("covered %0d edge inserts (%0d dropped as full), %0d traversals",
             n_adds, n_full, n_walks);
    $display("checked %0d result items, %0d arcs stored", n_checked, arc_used);
    if (errors == 0) begin
      $display("[graph_bfs_dfs_traversal] OK");
    end else begin
      $display("[graph_bfs_dfs_traversal] ERROR");
    end
    $finish;
  end

  // Result side: random back-pressure, compare against oldest prediction
  initial begin
    int        gap;
    rsp_item_t exp_item;
    rsp.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      gap = quiet ? 0 : $urandom_range(0, 13);
      if (gap > 0) begin
        rsp.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      rsp.ready <= 1'b1;
      do @(posedge clk_i); while (!rsp.valid);
      n_checked++;
      if (visit_q.size() == 0) begin
        report_mismatch("unexpected result vertex", rsp.visited_vertex, -1);
      end else begin
        exp_item = visit_q.pop_front();
        if (rsp.visited_vertex !== exp_item.vtx)
          report_mismatch("visited_vertex", rsp.visited_vertex, exp_item.vtx);
        if (rsp.status !== exp_item.status)
          report_mismatch("status", rsp.status, exp_item.status);
        if (rsp.last !== exp_item.last)
          report_mismatch("last", rsp.last, exp_item.last);
      end
    end
  end

  // Watchdog
  initial begin
    #60_000_000;
    $display("[graph_bfs_dfs_traversal] ERROR");
    $finish;
  end

endmodule
